/* rtl/gmcr_pkg.sv */
// gmcr_pkg: shared types and constants of the grid matrix codeword reader
// used by gmcr_front, gmcr_queue, gmcr_back and the top level; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package gmcr_pkg;

    localparam int LAYERS_W  = 4;
    localparam int POS_W     = 5;
    localparam int BITS_W    = 16;
    localparam int CW_W      = 7;
    localparam int ID_W      = 3;
    localparam int LIN_W     = 9;
    localparam int SQ_W      = 10;
    localparam int INDEX_W   = 11;
    localparam int EC_W      = 3;
    localparam int EC_PAIR_N = 5;
    localparam int TDATA_W   = 32;

    localparam logic [ID_W-1:0] UNSEEN_ID = 3'd7;
    localparam logic [EC_W-1:0] EC_NONE   = 3'd0;

    // error-correction level k+1 is selected by (centre id, first ring id) entry k
    localparam logic [ID_W-1:0] EC_CENTER_ID [EC_PAIR_N] = '{3'd3, 3'd3, 3'd2, 3'd1, 3'd0};
    localparam logic [ID_W-1:0] EC_RING_ID   [EC_PAIR_N] = '{3'd2, 3'd0, 3'd3, 3'd2, 3'd1};

    // one classified macromodule, handed from front to back
    typedef struct packed {
        logic               restart;    // clear ids before this item
        logic               is_center;
        logic               is_ring1;
        logic               last;
        logic [POS_W-1:0]   side;       // side length of the ring holding the item
        logic [LIN_W-1:0]   lin;        // two's complement offset from side*side-1
        logic [1:0]         layer_tag;
        logic [CW_W-1:0]    cw_first;
        logic [CW_W-1:0]    cw_second;
    } item_t;

endpackage

`default_nettype wire

/* rtl/gmcr_front.sv */
// gmcr_front: raster position counters and classification of each macromodule
// depends on gmcr_pkg
`timescale 1ns / 1ps
`default_nettype none

module gmcr_front #(
    parameter int MAX_LAYERS = 13
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire  [gmcr_pkg::LAYERS_W-1:0]    layers,
    input  wire                              in_valid,
    output logic                             in_ready,
    input  wire  [gmcr_pkg::BITS_W-1:0]      in_bits,
    output logic                             item_valid,
    input  wire                              item_ready,
    output gmcr_pkg::item_t                  item
);

    logic [gmcr_pkg::POS_W-1:0] row_count_reg, row_count_next;
    logic [gmcr_pkg::POS_W-1:0] col_count_reg, col_count_next;

    logic [gmcr_pkg::LAYERS_W-1:0] eff;
    logic [gmcr_pkg::POS_W-1:0]    two_eff, dim;
    logic                          restart;
    logic [gmcr_pkg::POS_W-1:0]    x, y, far_x, far_y, min_a, min_b, ring;
    logic [gmcr_pkg::POS_W-1:0]    side, sm1, xo, yo;
    logic [gmcr_pkg::LIN_W-1:0]    xo_w, yo_w, sm1_w, sm4_w, sm3_w, lin;
    logic                          last;

    assign eff     = (layers > gmcr_pkg::LAYERS_W'(MAX_LAYERS))
                     ? gmcr_pkg::LAYERS_W'(MAX_LAYERS) : layers;
    assign two_eff = {eff, 1'b0};
    assign dim     = {eff, 1'b1};

    // counters outside a shrunken grid start a new symbol
    assign restart = (row_count_reg >= dim) || (col_count_reg >= dim);
    assign x       = restart ? '0 : col_count_reg;
    assign y       = restart ? '0 : row_count_reg;

    assign far_x = two_eff - x;
    assign far_y = two_eff - y;
    assign min_a = (x < y) ? x : y;
    assign min_b = (far_x < far_y) ? far_x : far_y;
    assign ring  = (min_a < min_b) ? min_a : min_b;

    assign side  = {eff - ring[gmcr_pkg::LAYERS_W-1:0], 1'b1};
    assign sm1   = side - 5'd1;
    assign xo    = x - ring;
    assign yo    = y - ring;
    assign xo_w  = {4'b0, xo};
    assign yo_w  = {4'b0, yo};
    assign sm1_w = {4'b0, sm1};
    assign sm4_w = {2'b0, sm1, 2'b0};
    assign sm3_w = sm4_w - sm1_w;

    // offset along the ring: left, top, right, bottom side
    always_comb begin
        if (x == ring) begin
            lin = '0 - yo_w;
        end else if (y == ring) begin
            lin = xo_w - sm4_w;
        end else if (far_x == ring) begin
            lin = yo_w - sm3_w;
        end else begin
            lin = '0 - sm1_w - xo_w;
        end
    end

    assign last = (x == two_eff) && (y == two_eff);

    assign in_ready   = item_ready;
    assign item_valid = in_valid;

    always_comb begin
        item.restart   = restart;
        item.is_center = (x == {1'b0, eff}) && (y == {1'b0, eff});
        item.is_ring1  = (eff != '0) && (x == {1'b0, eff}) && (y == {1'b0, eff} - 5'd1);
        item.last      = last;
        item.side      = side;
        item.lin       = lin;
        item.layer_tag = in_bits[15:14];
        item.cw_first  = in_bits[6:0];
        item.cw_second = in_bits[13:7];
    end

    always_comb begin
        row_count_next = row_count_reg;
        col_count_next = col_count_reg;
        if (in_valid && item_ready) begin
            if (last) begin
                row_count_next = '0;
                col_count_next = '0;
            end else if (x + 5'd1 >= dim) begin
                row_count_next = y + 5'd1;
                col_count_next = '0;
            end else begin
                row_count_next = y;
                col_count_next = x + 5'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg <= '0;
            col_count_reg <= '0;
        end else begin
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/gmcr_queue.sv */
// gmcr_queue: two-entry queue of classified items between front and back
// depends on gmcr_pkg
`timescale 1ns / 1ps
`default_nettype none

module gmcr_queue (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 wr_valid,
    output logic                wr_ready,
    input  gmcr_pkg::item_t     wr_item,
    output logic                rd_valid,
    input  wire                 rd_ready,
    output gmcr_pkg::item_t     rd_item
);

    localparam int DEPTH = 2;

    gmcr_pkg::item_t entry_reg [DEPTH];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;
    logic            push, pop;

    assign wr_ready = (count_reg != 2'(DEPTH));
    assign rd_valid = (count_reg != 2'd0);
    assign rd_item  = entry_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/gmcr_back.sv */
// gmcr_back: spiral address, layer id tracking, level lookup and output register
// depends on gmcr_pkg
`timescale 1ns / 1ps
`default_nettype none

module gmcr_back (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                item_valid,
    output logic                               item_ready,
    input  gmcr_pkg::item_t                    item,
    output logic                               out_valid,
    input  wire                                out_ready,
    output logic [gmcr_pkg::INDEX_W-1:0]       out_index,
    output logic [gmcr_pkg::CW_W-1:0]          out_first,
    output logic [gmcr_pkg::CW_W-1:0]          out_second,
    output logic                               out_last,
    output logic [gmcr_pkg::EC_W-1:0]          out_ec
);

    logic                            out_valid_reg, out_valid_next;
    logic [gmcr_pkg::INDEX_W-1:0]    index_reg;
    logic [gmcr_pkg::CW_W-1:0]       first_reg, second_reg;
    logic                            last_reg;
    logic [gmcr_pkg::EC_W-1:0]       ec_reg, ec_next;
    logic [gmcr_pkg::ID_W-1:0]       center_id_reg, center_id_next;
    logic [gmcr_pkg::ID_W-1:0]       ring_one_id_reg, ring_one_id_next;
    logic [gmcr_pkg::ID_W-1:0]       center_cur, ring_cur;
    logic [gmcr_pkg::SQ_W-1:0]       sq;
    logic [gmcr_pkg::INDEX_W-1:0]    slot;
    logic                            take;

    assign item_ready = !out_valid_reg || out_ready;
    assign take       = item_valid && item_ready;

    assign sq   = {5'b0, item.side} * {5'b0, item.side};
    assign slot = {1'b0, sq} - 11'd1 + {{2{item.lin[gmcr_pkg::LIN_W-1]}}, item.lin};

    always_comb begin
        center_cur = item.restart ? gmcr_pkg::UNSEEN_ID : center_id_reg;
        ring_cur   = item.restart ? gmcr_pkg::UNSEEN_ID : ring_one_id_reg;
        if (item.is_center) begin
            center_cur = {1'b0, item.layer_tag};
        end
        if (item.is_ring1) begin
            ring_cur = {1'b0, item.layer_tag};
        end
    end

    // first matching pair wins
    always_comb begin
        ec_next = gmcr_pkg::EC_NONE;
        if (item.last) begin
            for (int i = gmcr_pkg::EC_PAIR_N - 1; i >= 0; i--) begin
                if (gmcr_pkg::EC_CENTER_ID[i] == center_cur &&
                    gmcr_pkg::EC_RING_ID[i] == ring_cur) begin
                    ec_next = gmcr_pkg::EC_W'(i + 1);
                end
            end
        end
    end

    always_comb begin
        out_valid_next   = take ? 1'b1 : (out_valid_reg && !out_ready);
        center_id_next   = center_id_reg;
        ring_one_id_next = ring_one_id_reg;
        if (take) begin
            center_id_next   = item.last ? gmcr_pkg::UNSEEN_ID : center_cur;
            ring_one_id_next = item.last ? gmcr_pkg::UNSEEN_ID : ring_cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            index_reg  <= {slot[gmcr_pkg::INDEX_W-2:0], 1'b0};
            first_reg  <= item.cw_first;
            second_reg <= item.cw_second;
            last_reg   <= item.last;
            ec_reg     <= ec_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg   <= 1'b0;
            center_id_reg   <= gmcr_pkg::UNSEEN_ID;
            ring_one_id_reg <= gmcr_pkg::UNSEEN_ID;
        end else begin
            out_valid_reg   <= out_valid_next;
            center_id_reg   <= center_id_next;
            ring_one_id_reg <= ring_one_id_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_index  = index_reg;
    assign out_first  = first_reg;
    assign out_second = second_reg;
    assign out_last   = last_reg;
    assign out_ec     = ec_reg;

endmodule

`default_nettype wire

/* rtl/grid_matrix_codeword_reader_unit.sv */
// grid_matrix_codeword_reader_unit: top level of the grid matrix codeword reader
// depends on gmcr_pkg, gmcr_front, gmcr_queue and gmcr_back
`timescale 1ns / 1ps
`default_nettype none

// Takes the 4x4 interiors of a grid matrix symbol's macromodules in raster order,
// one transfer each, and returns for each one transfer holding the spiral address
// of its first codeword, its two codewords, a last flag on the final macromodule,
// and on that final macromodule the error-correction level chosen by the layer ids
// of the centre and first ring macromodules (0 when no pair matches). The grid is
// 2*layers+1 macromodules per side; layers comes from cfg_wdata, resets to 1, and
// values above MAX_LAYERS act as MAX_LAYERS. Write it only while the block is idle.
// A new item is taken every cycle while the receiver keeps taking results; the front
// classifies in the cycle of the input transfer, and the item is then registered in
// the two-entry queue and then in the output register before its result transfer.

module grid_matrix_codeword_reader_unit #(
    parameter int MAX_LAYERS = 13
) (
    input  wire         aclk,
    input  wire         aresetn,

    // configuration: layers
    input  wire         cfg_we,
    input  wire  [3:0]  cfg_wdata,

    // input transfers
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,    // [15:0] macro_bits

    // result transfers
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,    // [10:0] codeword_index, [17:11] codeword_first,
                                    // [24:18] codeword_second, [27:25] ec_level
    output logic        m_tlast     // last_item
);

    // configuration register
    logic [gmcr_pkg::LAYERS_W-1:0] layers_reg, layers_next;

    // front to queue
    logic            front_valid, front_ready;
    gmcr_pkg::item_t front_item;

    // queue to back
    logic            queue_valid, queue_ready;
    gmcr_pkg::item_t queue_item;

    // back outputs
    logic [gmcr_pkg::INDEX_W-1:0] out_index;
    logic [gmcr_pkg::CW_W-1:0]    out_first, out_second;
    logic [gmcr_pkg::EC_W-1:0]    out_ec;

    assign layers_next = cfg_we ? cfg_wdata : layers_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            layers_reg <= 4'd1;
        end else begin
            layers_reg <= layers_next;
        end
    end

    // counters and classification
    gmcr_front #(
        .MAX_LAYERS (MAX_LAYERS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .layers     (layers_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_bits    (s_tdata),
        .item_valid (front_valid),
        .item_ready (front_ready),
        .item       (front_item)
    );

    // decouples front and back stalls
    gmcr_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_item  (front_item),
        .rd_valid (queue_valid),
        .rd_ready (queue_ready),
        .rd_item  (queue_item)
    );

    // address arithmetic, id tracking, level lookup
    gmcr_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (queue_valid),
        .item_ready (queue_ready),
        .item       (queue_item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_index  (out_index),
        .out_first  (out_first),
        .out_second (out_second),
        .out_last   (m_tlast),
        .out_ec     (out_ec)
    );

    // pack result fields, lowest field first
    assign m_tdata = {4'b0, out_ec, out_second, out_first, out_index};

endmodule

`default_nettype wire

/* tb/testbench.sv */
// testbench: self-checking bench for grid_matrix_codeword_reader_unit
// depends on gmcr_pkg and the rtl of the codeword reader; holds its own spiral predictor
`timescale 1ns / 1ps

// one result transfer as the predictor expects it
typedef struct packed {
    logic [10:0] index;
    logic [6:0]  first;
    logic [6:0]  second;
    logic        last;
    logic [2:0]  ec;
} codeword_result_t;

// tracks the raster position, the spiral address and the layer ids of the symbol
// being read, and keeps the results still owed by the block
class spiral_codeword_model;
    localparam int TOP_LAYERS = 13;
    localparam int MAX_PRINTS = 30;

    logic [3:0]       layers;
    int unsigned      row_pos;
    int unsigned      col_pos;
    logic [2:0]       centre_id;
    logic [2:0]       ring_id;
    codeword_result_t expected_codewords[$];
    int unsigned      accepted;
    int unsigned      mismatches;

    function new();
        layers     = 4'd1;
        accepted   = 0;
        mismatches = 0;
        start_symbol();
    endfunction

    function void start_symbol();
        row_pos   = 0;
        col_pos   = 0;
        centre_id = gmcr_pkg::UNSEEN_ID;
        ring_id   = gmcr_pkg::UNSEEN_ID;
    endfunction

    function int unsigned grid_dim();
        int unsigned eff;
        eff = (layers > TOP_LAYERS) ? TOP_LAYERS : layers;
        return 2 * eff + 1;
    endfunction

    // macromodule slot of column x, row y, counted outward from the centre
    function int unsigned spiral_slot(int unsigned dim, int unsigned x, int unsigned y);
        int unsigned ring;
        int unsigned side;
        int unsigned base;
        ring = x < y ? x : y;
        if (dim - 1 - x < ring) ring = dim - 1 - x;
        if (dim - 1 - y < ring) ring = dim - 1 - y;
        side = (((dim - 1) >> 1) - ring) * 2 + 1;
        base = side * side - 1;
        if (x == ring) return base - (y - ring);
        if (y == ring) return base - (side - 1) * 4 + (x - ring);
        if (x == dim - ring - 1) return base - (side - 1) * 3 + (y - ring);
        return base - (side - 1) - (x - ring);
    endfunction

    function bit out_of_grid();
        return row_pos >= grid_dim() || col_pos >= grid_dim();
    endfunction

    function int unsigned next_slot();
        if (out_of_grid()) return spiral_slot(grid_dim(), 0, 0);
        return spiral_slot(grid_dim(), col_pos, row_pos);
    endfunction

    function int unsigned pending();
        return expected_codewords.size();
    endfunction

    function void note_macromodule(logic [15:0] bits);
        codeword_result_t res;
        int unsigned      dim;
        int unsigned      addr;
        dim = grid_dim();
        if (out_of_grid()) start_symbol();
        addr = spiral_slot(dim, col_pos, row_pos) << 1;
        if (addr == 0) centre_id = {1'b0, bits[15:14]};
        else if (addr == 2) ring_id = {1'b0, bits[15:14]};
        res.index  = addr[10:0];
        res.first  = bits[6:0];
        res.second = bits[13:7];
        res.last   = (row_pos == dim - 1) && (col_pos == dim - 1);
        res.ec     = gmcr_pkg::EC_NONE;
        if (res.last) begin
            for (int k = 0; k < gmcr_pkg::EC_PAIR_N; k++) begin
                if (res.ec == gmcr_pkg::EC_NONE && gmcr_pkg::EC_CENTER_ID[k] == centre_id
                        && gmcr_pkg::EC_RING_ID[k] == ring_id)
                    res.ec = 3'(k + 1);
            end
            start_symbol();
        end else begin
            col_pos++;
            if (col_pos >= dim) begin
                col_pos = 0;
                row_pos++;
            end
        end
        expected_codewords.push_back(res);
        accepted++;
    endfunction

    task report(string what, int unsigned got, int unsigned want);
        if (mismatches < MAX_PRINTS)
            $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
        mismatches++;
    endtask

    task check_result(logic [31:0] tdata, logic tlast);
        codeword_result_t want;
        if (expected_codewords.size() == 0) begin
            report("unexpected transfer, index", tdata[10:0], 0);
            return;
        end
        want = expected_codewords.pop_front();
        if (tdata[10:0] !== want.index)   report("codeword_index", tdata[10:0], want.index);
        if (tdata[17:11] !== want.first)  report("codeword_first", tdata[17:11], want.first);
        if (tdata[24:18] !== want.second) report("codeword_second", tdata[24:18], want.second);
        if (tdata[27:25] !== want.ec)     report("ec_level", tdata[27:25], want.ec);
        if (tdata[31:28] !== 4'd0)        report("tdata padding", tdata[31:28], 0);
        if (tlast !== want.last)          report("last_item", tlast, want.last);
    endtask
endclass

module testbench;

    localparam int TB_MAX_LAYERS = 13;
    localparam int TOTAL_ITEMS   = 900;    // random part stops once this many are in
    localparam int BIG_START     = 100;    // largest grid begins once this many are in
    localparam int NOISE_PCT     = 15;     // items whose layer ids are left random
    localparam int HOLD_CYCLES   = 80;     // long receiver hold-off

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [3:0]  cfg_wdata = 4'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = 16'd0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;

    spiral_codeword_model codewords = new();

    int src_idle_pct = 11;
    int snk_idle_pct = 61;
    int sink_hold    = 0;
    int ec_pick      = 0;     // pair chosen for the symbol in flight, EC_PAIR_N means none

    grid_matrix_codeword_reader_unit #(
        .MAX_LAYERS (TB_MAX_LAYERS)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),      // [15:0] macro_bits
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),      // [10:0] index, [17:11] first, [24:18] second, [27:25] ec
        .m_tlast   (m_tlast)       // last_item
    );

    // 12 ns clock
    initial begin
        forever #6 aclk = ~aclk;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #(8_000_000);
        $display("testbench: FAIL");
        $finish;
    end

    // receiver: checks every result transfer, then picks next cycle's tready;
    // a pending hold-off keeps tready low for a whole stretch so the block backs up
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                codewords.check_result(m_tdata, m_tlast);
            if (sink_hold > 0) begin
                sink_hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
            end
        end
    end

    // idle pattern follows progress: sender light / receiver heavy, then swapped, then none
    function automatic void pick_idle_mode();
        if (codewords.accepted < TOTAL_ITEMS / 3) begin
            src_idle_pct = 11;
            snk_idle_pct = 61;
        end else if (codewords.accepted < 2 * TOTAL_ITEMS / 3) begin
            src_idle_pct = 61;
            snk_idle_pct = 11;
        end else begin
            src_idle_pct = 0;
            snk_idle_pct = 0;
        end
    endfunction

    // one input transfer; tvalid stays high into the next item unless a gap is drawn
    task automatic send_macromodule(logic [15:0] bits);
        pick_idle_mode();
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= bits;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        codewords.note_macromodule(bits);
    endtask

    // random module bits; on the first ring slot a table pair is drawn and its ring id
    // placed, on the centre slot the matching centre id, so most symbols hit a level
    function automatic logic [15:0] make_bits(logic [15:0] base, int pair_sel, bit steer);
        logic [15:0] bits;
        int unsigned slot;
        bits = base;
        slot = codewords.next_slot();
        if (steer && slot == 1) begin
            ec_pick = (pair_sel >= 0) ? pair_sel : $urandom_range(0, gmcr_pkg::EC_PAIR_N);
            if (ec_pick < gmcr_pkg::EC_PAIR_N)
                bits[15:14] = gmcr_pkg::EC_RING_ID[ec_pick][1:0];
        end else if (steer && slot == 0 && ec_pick < gmcr_pkg::EC_PAIR_N) begin
            bits[15:14] = gmcr_pkg::EC_CENTER_ID[ec_pick][1:0];
        end
        return bits;
    endfunction

    // stop offering, then wait until every result transfer has come back
    task automatic finish_batch();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (codewords.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // register write, only while the block is idle
    task automatic write_layers(int value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value[3:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        codewords.layers = value[3:0];
    endtask

    // mostly small grids, some mid, some above range, the largest now and then
    function automatic int pick_layers();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return $urandom_range(0, 3);
        if (r < 80) return $urandom_range(4, 12);
        if (r < 92) return $urandom_range(14, 15);
        return 13;
    endfunction

    initial begin
        int  v;
        int  n;
        int  dim;
        bit  big_done;

        big_done = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // single-macromodule grid: each transfer is centre and last, never a level
        write_layers(0);
        send_macromodule(16'h0000);
        send_macromodule(16'hFFFF);
        finish_batch();

        // 3x3 grid with all-zero / all-one content and the first table pair
        write_layers(1);
        for (int k = 0; k < 9; k++)
            send_macromodule(make_bits(k[0] ? 16'hFFFF : 16'h0000, 0, 1'b1));
        // same grid, last table pair, random content
        for (int k = 0; k < 9; k++)
            send_macromodule(make_bits(16'($urandom_range(0, 65535)),
                                       gmcr_pkg::EC_PAIR_N - 1, 1'b1));
        finish_batch();

        // random phases; partial symbols left behind let a smaller grid restart at (0,0)
        while (codewords.accepted < TOTAL_ITEMS) begin
            if (!big_done && codewords.accepted >= BIG_START) begin
                // largest grid until its symbol closes, starting with a long hold-off
                write_layers(TB_MAX_LAYERS);
                sink_hold = HOLD_CYCLES;
                do begin
                    send_macromodule(make_bits(16'($urandom_range(0, 65535)), -1,
                                               $urandom_range(0, 99) >= NOISE_PCT));
                end while (!(codewords.row_pos == 0 && codewords.col_pos == 0));
                big_done = 1'b1;
            end else begin
                v   = pick_layers();
                dim = 2 * ((v > TB_MAX_LAYERS) ? TB_MAX_LAYERS : v) + 1;
                n   = $urandom_range(1, 2 * dim * dim);
                if (n > 60) n = $urandom_range(20, 60);
                write_layers(v);
                repeat (n)
                    send_macromodule(make_bits(16'($urandom_range(0, 65535)), -1,
                                               $urandom_range(0, 99) >= NOISE_PCT));
            end
            finish_batch();
        end

        repeat (8) @(posedge aclk);
        if (codewords.mismatches == 0 && codewords.pending() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/gmcr_pkg.sv
rtl/gmcr_front.sv
rtl/gmcr_queue.sv
rtl/gmcr_back.sv
rtl/grid_matrix_codeword_reader_unit.sv
tb/testbench.sv
